// ===== sv/number_morse_pattern_player_defines.svh =====
// assertion macros for the number morse pattern player
// expects clk_i and rst_ni in the scope of every use
`ifndef NUMBER_MORSE_PATTERN_PLAYER_DEFINES_SVH
`define NUMBER_MORSE_PATTERN_PLAYER_DEFINES_SVH

// property that holds at every clock edge outside reset
`define NMPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define NMPP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/nmpp_pkg.sv =====
// shared types, codes and symbol tables of the number morse pattern player
// no dependencies
`default_nettype none

package nmpp_pkg;

  localparam int unsigned MAX_DIGITS = 4;
  localparam int unsigned NUM_W      = 14;
  localparam int unsigned NUM_BCD    = 5;   // a 14 bit value has at most five digits
  localparam int unsigned CNT_W      = 3;

  localparam logic [2:0] MAX_CODE_LEN = 3'd4;

  // phase codes on the result word
  localparam logic [2:0] PH_FETCH = 3'd0;
  localparam logic [2:0] PH_DOT   = 3'd1;
  localparam logic [2:0] PH_DASH  = 3'd2;
  localparam logic [2:0] PH_SPACE = 3'd3;
  localparam logic [2:0] PH_PAUSE = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_DOT   = 2'd0;
  localparam logic [1:0] REG_DASH  = 2'd1;
  localparam logic [1:0] REG_GAP   = 2'd2;
  localparam logic [1:0] REG_PAUSE = 2'd3;

  typedef enum logic [5:0] {
    ST_FETCH = 6'b000001,
    ST_DOT   = 6'b000010,
    ST_DASH  = 6'b000100,
    ST_SPACE = 6'b001000,
    ST_PAUSE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic             opcode;
    logic [NUM_W-1:0] number;
    logic [7:0]       multiplier;
  } in_word_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       vibrating;
  } out_word_t;

  // item after the digit split: digits[0] is the ones digit
  typedef struct packed {
    logic                        opcode;
    logic [7:0]                  multiplier;
    logic [CNT_W-1:0]            cnt;
    logic [NUM_BCD-1:0][3:0]     digits;
  } split_word_t;

  // number of symbols of a digit code
  function automatic logic [2:0] code_len(input logic [3:0] d);
    logic [2:0] len;
    case (d)
      4'd0:    len = 3'd2;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd3;
      default: len = 3'd2;
    endcase
    return len;
  endfunction

  // bit i set: symbol i of the digit code is a dash
  function automatic logic [3:0] code_dash(input logic [3:0] d);
    logic [3:0] m;
    case (d)
      4'd0:    m = 4'b0011;
      4'd1:    m = 4'b0000;
      4'd2:    m = 4'b0000;
      4'd3:    m = 4'b0000;
      4'd4:    m = 4'b0010;
      4'd5:    m = 4'b0001;
      4'd6:    m = 4'b0001;
      4'd7:    m = 4'b0001;
      4'd8:    m = 4'b0001;
      4'd9:    m = 4'b0110;
      default: m = 4'b0011;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] phase_code(input state_e st);
    logic [2:0] p;
    case (st)
      ST_FETCH: p = PH_FETCH;
      ST_DOT:   p = PH_DOT;
      ST_DASH:  p = PH_DASH;
      ST_SPACE: p = PH_SPACE;
      ST_PAUSE: p = PH_PAUSE;
      default:  p = PH_DONE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nmpp_split.sv =====
// four stage elastic pipeline that clamps the number and splits it into digits
// depends on nmpp_pkg
`default_nettype none

module nmpp_split
  import nmpp_pkg::*;
#(
  parameter int unsigned MaxDigits = MAX_DIGITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output split_word_t      out_word_o
);

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  localparam int unsigned Limit   = pow10(MaxDigits) - 1;
  localparam int unsigned ProdW   = NUM_W + 13;
  localparam int unsigned Div100M = 5243;   // floor(x/100) = (x*5243) >> 19 for x < 43699

  // value 0..255 to three bcd digits by compares
  function automatic logic [11:0] to_bcd3(input logic [7:0] v);
    logic [1:0] h;
    logic [7:0] rem;
    logic [3:0] t;
    logic [7:0] o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    rem = v - 8'(h) * 8'd100;
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 8'(10 * k)) t = 4'(k);
    end
    o = rem - 8'(t) * 8'd10;
    return {2'b00, h, t, o[3:0]};
  endfunction

  logic [3:0] v_q;
  logic [3:0] load;

  assign load[3] = !v_q[3] || out_ready_i;
  assign load[2] = !v_q[2] || load[3];
  assign load[1] = !v_q[1] || load[2];
  assign load[0] = !v_q[0] || load[1];

  assign in_ready_o  = load[0];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (load[0]) v_q[0] <= in_valid_i;
      if (load[1]) v_q[1] <= v_q[0];
      if (load[2]) v_q[2] <= v_q[1];
      if (load[3]) v_q[3] <= v_q[2];
    end
  end

  // stage a: raw input word
  in_word_t a_q;

  // stage b: clamp, digit count, quotient by 100
  logic [NUM_W-1:0] num_c;
  logic [CNT_W-1:0] cnt_c;
  logic [ProdW-1:0] prod_c;

  always_comb begin
    num_c = (32'(a_q.number) > Limit) ? NUM_W'(Limit) : a_q.number;
    cnt_c = CNT_W'(num_c != '0) + CNT_W'(num_c >= NUM_W'(10)) + CNT_W'(num_c >= NUM_W'(100))
          + CNT_W'(num_c >= NUM_W'(1000)) + CNT_W'(num_c >= NUM_W'(10000));
    prod_c = ProdW'(num_c) * ProdW'(Div100M);
  end

  logic             b_op;
  logic [7:0]       b_mult;
  logic [NUM_W-1:0] b_num;
  logic [7:0]       b_quo;
  logic [CNT_W-1:0] b_cnt;

  // stage c: remainder by 100
  logic [NUM_W-1:0] rem_c;
  assign rem_c = b_num - NUM_W'(b_quo) * NUM_W'(100);

  logic             c_op;
  logic [7:0]       c_mult;
  logic [7:0]       c_quo;
  logic [6:0]       c_rem;
  logic [CNT_W-1:0] c_cnt;

  // stage d: bcd digits
  logic [11:0] quo_bcd;
  logic [11:0] rem_bcd;
  assign quo_bcd = to_bcd3(c_quo);
  assign rem_bcd = to_bcd3({1'b0, c_rem});

  split_word_t d_q;

  always_ff @(posedge clk_i) begin
    if (load[0] && in_valid_i) a_q <= in_word_i;
    if (load[1] && v_q[0]) begin
      b_op   <= a_q.opcode;
      b_mult <= a_q.multiplier;
      b_num  <= num_c;
      b_quo  <= prod_c[ProdW-1:19];
      b_cnt  <= cnt_c;
    end
    if (load[2] && v_q[1]) begin
      c_op   <= b_op;
      c_mult <= b_mult;
      c_quo  <= b_quo;
      c_rem  <= rem_c[6:0];
      c_cnt  <= b_cnt;
    end
    if (load[3] && v_q[2]) begin
      d_q.opcode     <= c_op;
      d_q.multiplier <= c_mult;
      d_q.cnt        <= c_cnt;
      d_q.digits     <= {quo_bcd[11:0], rem_bcd[7:0]};
    end
  end

  assign out_word_o = d_q;

endmodule

`default_nettype wire

// ===== sv/number_morse_pattern_player.sv =====
// top level of the number morse pattern player: timing state machine and result register
// depends on nmpp_pkg, nmpp_split and number_morse_pattern_player_defines.svh
//
// usage
// - in channel (in_valid_i / in_ready_o / in_word_i): one word per step; opcode 1 starts
//   playing number at the given length multiplier (ignored while a message plays),
//   opcode 0 is one tick of time
// - out channel (out_valid_o / out_ready_i / out_word_o): exactly one word per input word,
//   in order, giving the phase after that step and whether the motor is on
// - cfg channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): base lengths of
//   dot, dash, inter-digit space and the pause; always ready; write only when idle;
//   a new length is used at the next load of the hold counter
// - path: from input accept to result valid a word passes the input register and three
//   split stages, then the state update into the result register
// - throughput: one word per cycle while out_ready_i is high; the digit split is pipelined
//   ahead of the single state update stage, so each word still sees the state left by the word before
// - receiver stall: a full stage holds its word until the stage after it has room, so
//   up to five words are taken in while out_ready_i is low before in_ready_o drops
// - reset: all stages empty, phase done, not playing, base lengths 1, 3, 3, 1
`default_nettype none
`include "number_morse_pattern_player_defines.svh"

module number_morse_pattern_player
  import nmpp_pkg::*;
#(
  parameter int unsigned MaxDigits = MAX_DIGITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_word_t        out_word_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int unsigned DtotW = $clog2(MaxDigits + 1);
  localparam int unsigned DidxW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;

  // configuration registers
  logic [7:0] cfg_dot_q, cfg_dash_q, cfg_gap_q, cfg_pause_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dot_q   <= 8'd1;
      cfg_dash_q  <= 8'd3;
      cfg_gap_q   <= 8'd3;
      cfg_pause_q <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DOT:   cfg_dot_q   <= cfg_data_i;
        REG_DASH:  cfg_dash_q  <= cfg_data_i;
        REG_GAP:   cfg_gap_q   <= cfg_data_i;
        REG_PAUSE: cfg_pause_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // digit split pipeline
  split_word_t sw;
  logic        sw_valid;
  logic        sw_ready;
  logic        adv;

  nmpp_split #(
    .MaxDigits(MaxDigits)
  ) u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (sw_valid),
    .out_ready_i (sw_ready),
    .out_word_o  (sw)
  );

  // result register: the state stage fires when its slot is free or being emptied
  logic      out_valid_q;
  out_word_t out_word_q;

  assign sw_ready    = !out_valid_q || out_ready_i;
  assign adv         = sw_valid && sw_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // playback state
  state_e           st_q, st_d;
  logic             active_q, active_d;
  logic [DtotW-1:0] dtot_q, dtot_d;
  logic [DtotW-1:0] dpos_q, dpos_d;
  logic [2:0]       spos_q, spos_d;
  logic [7:0]       tick_q, tick_d;
  logic [7:0]       mult_q, mult_d;   // length multiplier, set on start
  logic [3:0]       store_q [MaxDigits];

  logic             start_go;
  logic [7:0]       hold_base;
  logic [15:0]      hold_prod;
  logic [3:0]       cur_digit;
  logic [2:0]       cur_len;
  logic [3:0]       cur_dash;
  logic [7:0]       tick_dec;
  logic             dot_last;

  assign start_go = adv && sw.opcode && !active_q;

  // digit under playback, with codes above nine played as zero, and the
  // base length of the hold that the next fetch loads
  always_comb begin
    cur_digit = store_q[dpos_q[DidxW-1:0]];
    if (cur_digit > 4'd9) cur_digit = 4'd0;
    cur_len  = code_len(cur_digit);
    cur_dash = code_dash(cur_digit);
    if (spos_q >= cur_len) begin
      hold_base = cfg_gap_q;
    end else if (cur_dash[spos_q[1:0]]) begin
      hold_base = cfg_dash_q;
    end else begin
      hold_base = cfg_dot_q;
    end
  end

  // current base length times the multiplier, wrapped to the 8 bit counter
  assign hold_prod = 16'(hold_base) * 16'(mult_q);
  assign tick_dec  = tick_q - 8'd1;

  always_comb begin
    st_d     = st_q;
    active_d = active_q;
    dtot_d   = dtot_q;
    dpos_d   = dpos_q;
    spos_d   = spos_q;
    tick_d   = tick_q;
    mult_d   = mult_q;
    if (sw.opcode) begin
      if (!active_q) begin
        st_d     = ST_FETCH;
        active_d = 1'b1;
        dtot_d   = DtotW'(sw.cnt);
        dpos_d   = '0;
        spos_d   = 3'd0;
        tick_d   = 8'd1;
        mult_d   = sw.multiplier;
      end
    end else if (active_q) begin
      case (st_q)
        ST_FETCH: begin
          if (dpos_q >= dtot_q) begin
            // message finished
            st_d     = ST_DONE;
            active_d = 1'b0;
          end else if (spos_q < cur_len) begin
            if (cur_dash[spos_q[1:0]]) begin
              st_d = ST_DASH;
            end else begin
              st_d = ST_DOT;
            end
            tick_d = hold_prod[7:0];
            spos_d = spos_q + 3'd1;
          end else begin
            // code of this digit done, space before the next one
            st_d   = ST_SPACE;
            tick_d = hold_prod[7:0];
            spos_d = 3'd0;
            dpos_d = dpos_q + DtotW'(1);
          end
        end
        ST_DOT, ST_DASH: begin
          tick_d = tick_dec;
          if (tick_dec == 8'd0) begin
            st_d   = ST_PAUSE;
            tick_d = cfg_pause_q;
          end
        end
        ST_SPACE, ST_PAUSE: begin
          tick_d = tick_dec;
          if (tick_dec == 8'd0) st_d = ST_FETCH;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_DONE;
      active_q    <= 1'b0;
      dtot_q      <= '0;
      dpos_q      <= '0;
      spos_q      <= 3'd0;
      tick_q      <= 8'd0;
      mult_q      <= 8'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        st_q        <= st_d;
        active_q    <= active_d;
        dtot_q      <= dtot_d;
        dpos_q      <= dpos_d;
        spos_q      <= spos_d;
        tick_q      <= tick_d;
        mult_q      <= mult_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: result word and the digit store
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q.phase     <= phase_code(st_d);
      out_word_q.vibrating <= (st_d == ST_DOT) || (st_d == ST_DASH);
    end
    if (start_go) begin
      // most significant digit goes to entry zero
      for (int i = 0; i < MaxDigits; i++) begin
        if (3'(i) < sw.cnt) store_q[i] <= sw.digits[3'(sw.cnt - 3'd1 - 3'(i))];
      end
    end
  end

  // tick that ends a dot, taken while the hold counter is at one
  assign dot_last = adv && !sw.opcode && active_q && (st_q == ST_DOT) && (tick_q == 8'd1);

  `NMPP_ASSERT(a_active_done, active_q != (st_q == ST_DONE), "playing flag and done phase disagree")
  `NMPP_ASSERT(a_dpos_range, dpos_q <= dtot_q, "digit position past message end")
  `NMPP_ASSERT(a_spos_range, spos_q <= MAX_CODE_LEN, "symbol position past longest code")
  `NMPP_ASSERT_NEXT(a_dot_to_pause, dot_last, st_q == ST_PAUSE, "dot did not end in pause")

endmodule

`default_nettype wire
